/* hw/rtl/u8v_pkg.sv */
// Shared types and constants for the UTF-8 validator with line locator.
package u8v_pkg;

  localparam int unsigned LINE_W         = 21;
  localparam int unsigned MAX_TEXT_BYTES = 1048576;
  localparam int unsigned LINE_MAX       = (1 << LINE_W) - 1;
  localparam int unsigned LINE_CAP_INT   =
    (MAX_TEXT_BYTES + 1 < LINE_MAX) ? MAX_TEXT_BYTES + 1 : LINE_MAX;
  localparam logic [LINE_W-1:0] LINE_CAP   = LINE_W'(LINE_CAP_INT);
  localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);

  // Byte codes that steer the decoder.
  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_LO        = 8'h80;
  localparam logic [7:0] CONT_HI        = 8'hBF;
  localparam logic [7:0] LEAD2_LO       = 8'hC2;
  localparam logic [7:0] LEAD2_HI       = 8'hDF;
  localparam logic [7:0] LEAD3_LO       = 8'hE0;
  localparam logic [7:0] LEAD3_HI       = 8'hEF;
  localparam logic [7:0] LEAD4_LO       = 8'hF0;
  localparam logic [7:0] LEAD4_HI       = 8'hF4;
  localparam logic [7:0] LEAD_E0        = 8'hE0;
  localparam logic [7:0] LEAD_ED        = 8'hED;
  localparam logic [7:0] LEAD_F0        = 8'hF0;
  localparam logic [7:0] LEAD_F4        = 8'hF4;
  localparam logic [7:0] E0_SECOND_MIN  = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX  = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN  = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX  = 8'h8F;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_ONE   = 2'd1;
  localparam logic [1:0] PEND_TWO   = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic              text_ok;
    logic [LINE_W-1:0] bad_line;
  } out_word_t;

  // Result handed from the checker to the output register.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

  // Handoff from the input register to the checker.
  typedef struct packed {
    logic     step;
    in_word_t word;
  } stage_t;

endpackage

/* hw/rtl/utf8_validator_line_locator.sv */
// Top level of the strict UTF-8 validator with line locator.
// A byte word is captured in the input register and checked; if it is the last
//   byte, its result is registered in the output register, which raises out_valid.
// Throughput: one byte word per cycle; the only wait is a last byte whose
//   result would land on a still-stalled output register.
// Reset (rst_n low, synchronous): registers empty, line at 1, no open sequence or error.
module utf8_validator_line_locator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  u8v_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output u8v_pkg::out_word_t out_word
);

  // Handoff from the input register into the checker.
  u8v_pkg::stage_t stage;
  // Result of a last byte, loaded into the output register.
  u8v_pkg::res_t   res;
  // Output register can take a result this cycle.
  logic            out_free;

  // Stage 1: capture the incoming word; hold a last byte while the output is full.
  u8v_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_free (out_free),
    .stage    (stage)
  );

  // Check the byte against the open sequence, advance the line counter,
  // and latch the first error with its line.
  u8v_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .stage (stage),
    .res   (res)
  );

  // Stage 2: hold the result until the receiver drops out_stall.
  u8v_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* hw/rtl/u8v_in_reg.sv */
// Input register: holds one byte word and releases it; a last byte only when the result side has room.
module u8v_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  u8v_pkg::in_word_t in_word,
  input  logic              out_free,
  output u8v_pkg::stage_t   stage
);

  logic              valid_r;
  logic              valid_nxt;
  u8v_pkg::in_word_t word_r;
  logic              advance;
  logic              accept;

  // A non-last word never produces a result, so it always moves on.
  assign advance   = valid_r && (!word_r.is_last || out_free);
  assign in_stall  = valid_r && !advance;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_word;
    end
  end

  assign stage.step = advance;
  assign stage.word = word_r;

endmodule

/* hw/rtl/u8v_checker.sv */
// Decoder state and per-byte validation step; produces the end-of-text result.
module u8v_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  u8v_pkg::stage_t stage,
  output u8v_pkg::res_t   res
);

  logic [u8v_pkg::LINE_W-1:0] line_count_r,    line_count_nxt;
  logic [1:0]                 bytes_pending_r, bytes_pending_nxt;
  logic [7:0]                 lead_value_r,    lead_value_nxt;
  logic                       expect_second_r, expect_second_nxt;
  logic                       error_seen_r,    error_seen_nxt;

  logic [u8v_pkg::LINE_W-1:0] line_upd;
  logic [1:0]                 pend_upd;
  logic [7:0]                 lead_upd;
  logic                       exp_upd;
  logic                       err_upd;
  logic                       fin_err;
  logic [7:0]                 b;
  logic                       is_cont;
  logic                       second_ok;

  assign b       = stage.word.text_byte;
  assign is_cont = (b >= u8v_pkg::CONT_LO) && (b <= u8v_pkg::CONT_HI);

  always_comb begin
    second_ok = 1'b1;
    if (lead_value_r == u8v_pkg::LEAD_E0 && b < u8v_pkg::E0_SECOND_MIN) second_ok = 1'b0;
    if (lead_value_r == u8v_pkg::LEAD_ED && b > u8v_pkg::ED_SECOND_MAX) second_ok = 1'b0;
    if (lead_value_r == u8v_pkg::LEAD_F0 && b < u8v_pkg::F0_SECOND_MIN) second_ok = 1'b0;
    if (lead_value_r == u8v_pkg::LEAD_F4 && b > u8v_pkg::F4_SECOND_MAX) second_ok = 1'b0;
  end

  // Byte update: drop everything once an error is latched.
  always_comb begin
    line_upd = line_count_r;
    pend_upd = bytes_pending_r;
    lead_upd = lead_value_r;
    exp_upd  = expect_second_r;
    err_upd  = error_seen_r;
    if (!error_seen_r) begin
      if (bytes_pending_r != u8v_pkg::PEND_NONE) begin
        if (!is_cont || (expect_second_r && !second_ok)) begin
          err_upd = 1'b1;
        end else begin
          pend_upd = bytes_pending_r - 2'd1;
          exp_upd  = 1'b0;
        end
      end else begin
        priority if (b <= u8v_pkg::BYTE_ASCII_MAX) begin
          if (b == u8v_pkg::BYTE_LF && line_count_r < u8v_pkg::LINE_CAP) begin
            line_upd = line_count_r + u8v_pkg::LINE_W'(1);
          end
        end else if (b >= u8v_pkg::LEAD2_LO && b <= u8v_pkg::LEAD2_HI) begin
          pend_upd = u8v_pkg::PEND_ONE;
          lead_upd = b;
          exp_upd  = 1'b1;
        end else if (b >= u8v_pkg::LEAD3_LO && b <= u8v_pkg::LEAD3_HI) begin
          pend_upd = u8v_pkg::PEND_TWO;
          lead_upd = b;
          exp_upd  = 1'b1;
        end else if (b >= u8v_pkg::LEAD4_LO && b <= u8v_pkg::LEAD4_HI) begin
          pend_upd = u8v_pkg::PEND_THREE;
          lead_upd = b;
          exp_upd  = 1'b1;
        end else begin
          err_upd = 1'b1;
        end
      end
    end
  end

  // Close the text on the last byte: an open sequence is an error.
  assign fin_err = err_upd || (pend_upd != u8v_pkg::PEND_NONE);

  always_comb begin
    res.valid         = stage.step && stage.word.is_last;
    res.word.text_ok  = !fin_err;
    res.word.bad_line = fin_err ? line_upd : '0;

    line_count_nxt    = line_count_r;
    bytes_pending_nxt = bytes_pending_r;
    lead_value_nxt    = lead_value_r;
    expect_second_nxt = expect_second_r;
    error_seen_nxt    = error_seen_r;
    if (stage.step) begin
      if (stage.word.is_last) begin
        line_count_nxt    = u8v_pkg::LINE_FIRST;
        bytes_pending_nxt = u8v_pkg::PEND_NONE;
        lead_value_nxt    = '0;
        expect_second_nxt = 1'b0;
        error_seen_nxt    = 1'b0;
      end else begin
        line_count_nxt    = line_upd;
        bytes_pending_nxt = pend_upd;
        lead_value_nxt    = lead_upd;
        expect_second_nxt = exp_upd;
        error_seen_nxt    = err_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r    <= u8v_pkg::LINE_FIRST;
      bytes_pending_r <= u8v_pkg::PEND_NONE;
      lead_value_r    <= '0;
      expect_second_r <= 1'b0;
      error_seen_r    <= 1'b0;
    end else begin
      line_count_r    <= line_count_nxt;
      bytes_pending_r <= bytes_pending_nxt;
      lead_value_r    <= lead_value_nxt;
      expect_second_r <= expect_second_nxt;
      error_seen_r    <= error_seen_nxt;
    end
  end

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    (line_count_r >= u8v_pkg::LINE_FIRST) && (line_count_r <= u8v_pkg::LINE_CAP))
    else $error("line counter out of range");

  a_second_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    expect_second_r |-> (bytes_pending_r != u8v_pkg::PEND_NONE))
    else $error("second-byte check armed with no open sequence");

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (error_seen_r && !(stage.step && stage.word.is_last)) |=>
      (error_seen_r && $stable(line_count_r)))
    else $error("latched error or its line changed before end of text");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.step && stage.word.is_last) |=>
      (line_count_r == u8v_pkg::LINE_FIRST && bytes_pending_r == u8v_pkg::PEND_NONE
       && !error_seen_r))
    else $error("state not cleared after last byte");

endmodule

/* hw/rtl/u8v_out_reg.sv */
// Result register: holds one result word until the receiver takes it.
module u8v_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  u8v_pkg::res_t      res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_stall,
  output u8v_pkg::out_word_t out_word
);

  logic               valid_r;
  logic               valid_nxt;
  u8v_pkg::out_word_t word_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      word_r <= res.word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result arrived while output register was full");

endmodule
